### design/rrs_pkg.sv
// Shared types and constants for the replay ring with shuffled readout.
`default_nettype none
package rrs_pkg;

	localparam int MAX_ENTRIES_DEF   = 1024;
	localparam int MAX_ROW_WORDS_DEF = 16;

	localparam int DATA_W     = 64;
	localparam int CAP_W      = 11;
	localparam int ROWW_W     = 5;
	localparam int BATCH_W    = 11;
	localparam int SEED_W     = 32;
	localparam int STORED_W   = 11;
	localparam int TDATA_W    = 80;
	localparam int TUSER_W    = 3;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CAP_W-1:0]  CAP_RST   = 11'd1024;
	localparam logic [ROWW_W-1:0] ROWW_RST  = 5'd16;
	localparam logic [BATCH_W-1:0] BATCH_RST = 11'd32;
	localparam logic [SEED_W-1:0] SEED_RST  = 32'd5489;

	// MT19937
	localparam int MT_N  = 624;
	localparam int MT_M  = 397;
	localparam int MT_IW = 10;
	localparam logic [31:0] MT_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
	localparam logic [31:0] MT_TMASK_B = 32'h9d2c_5680;
	localparam logic [31:0] MT_TMASK_C = 32'hefc6_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY  = 2'd0,
		REG_ROW_WORDS = 2'd1,
		REG_BATCH     = 2'd2,
		REG_SEED      = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_PULL   = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [DATA_W-1:0]  word;
	} cmd_t;

	typedef struct packed {
		logic        busy;
		logic        ack;
		logic [31:0] key;
	} mt_rsp_t;

endpackage
`default_nettype wire

### design/rrs_ram.sv
// Generic one-write one-read RAM with registered read data.
`default_nettype none
module rrs_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [((D>1)?$clog2(D):1)-1:0] waddr,
	input  wire logic [W-1:0]                  wdata,
	input  wire logic [((D>1)?$clog2(D):1)-1:0] raddr,
	output logic      [W-1:0]                  rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### design/rrs_front.sv
// Input side: takes words, tags them append or pull, and queues them two deep.
`default_nettype none
module rrs_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [rrs_pkg::DATA_W-1:0] s_tdata,
	input  wire logic                     s_tuser,
	output rrs_pkg::cmd_t                 cmd,
	output logic                          cmd_valid,
	input  wire logic                     cmd_pop
);
	rrs_pkg::cmd_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	rrs_pkg::cmd_t in_cmd;

	always_comb begin
		in_cmd.kind = s_tuser ? rrs_pkg::CMD_PULL : rrs_pkg::CMD_APPEND;
		in_cmd.word = s_tdata;
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			ent_q[0] <= '0;
			ent_q[1] <= '0;
		end else begin
			if (push) begin
				ent_q[wr_ptr_q] <= in_cmd;
				wr_ptr_q        <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/rrs_mt.sv
// MT19937 key generator: seeding pass, in-place twist and tempered draws.
`default_nettype none
module rrs_mt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [rrs_pkg::SEED_W-1:0] seed,
	input  wire logic                       reseed,
	input  wire logic                       draw_req,
	output rrs_pkg::mt_rsp_t                rsp
);
	localparam int IW = rrs_pkg::MT_IW;
	localparam logic [IW-1:0] LAST_I = IW'(rrs_pkg::MT_N - 1);
	localparam logic [IW-1:0] N_I    = IW'(rrs_pkg::MT_N);
	localparam logic [IW-1:0] M_I    = IW'(rrs_pkg::MT_M);

	typedef enum logic [3:0] {
		M_SEED0, M_SMUL, M_SADD, M_IDLE, M_TA, M_TB, M_TC, M_TW, M_DRD, M_DTMP
	} mt_state_t;

	mt_state_t      state_q;
	logic [IW-1:0]  i_q;
	logic [IW-1:0]  idx_q;
	logic [31:0]    p_q;
	logic [31:0]    prod_q;
	logic [31:0]    a_q;
	logic [31:0]    b_q;
	logic [31:0]    key_q;
	logic           ack_q;

	logic           we;
	logic [IW-1:0]  waddr;
	logic [31:0]    wdata;
	logic [IW-1:0]  raddr;
	logic [31:0]    rdata;
	logic [IW-1:0]  i_next1;
	logic [IW-1:0]  i_far;
	logic [IW:0]    i_far_sum;
	logic [31:0]    x;
	logic [31:0]    xa;
	logic [31:0]    twisted;
	logic [31:0]    seed_next;
	logic [31:0]    t0, t1, t2, t3;

	assign i_next1   = (i_q == LAST_I) ? '0 : i_q + 1'b1;
	assign i_far_sum = {1'b0, i_q} + {1'b0, M_I};
	assign i_far     = (i_far_sum >= {1'b0, N_I}) ? IW'(i_far_sum - {1'b0, N_I})
	                                              : i_far_sum[IW-1:0];
	assign x         = (a_q & 32'h8000_0000) | (b_q & 32'h7fff_ffff);
	assign xa        = (x >> 1) ^ (x[0] ? rrs_pkg::MT_MATRIX : 32'd0);
	assign twisted   = rdata ^ xa;
	assign seed_next = prod_q + 32'(i_q);

	assign t0 = rdata ^ (rdata >> 11);
	assign t1 = t0 ^ ((t0 << 7) & rrs_pkg::MT_TMASK_B);
	assign t2 = t1 ^ ((t1 << 15) & rrs_pkg::MT_TMASK_C);
	assign t3 = t2 ^ (t2 >> 18);

	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = seed_next;
		raddr = i_q;
		case (state_q)
			M_SEED0: begin
				we    = 1'b1;
				waddr = '0;
				wdata = seed;
			end
			M_SADD: we = 1'b1;
			M_TB:   raddr = i_next1;
			M_TC:   raddr = i_far;
			M_TW: begin
				we    = 1'b1;
				wdata = twisted;
			end
			M_DRD:  raddr = idx_q;
			default: ;
		endcase
	end

	rrs_ram #(.W(32), .D(rrs_pkg::MT_N)) u_state (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_SEED0;
			i_q     <= '0;
			idx_q   <= N_I;
			p_q     <= '0;
			prod_q  <= '0;
			a_q     <= '0;
			b_q     <= '0;
			key_q   <= '0;
			ack_q   <= 1'b0;
		end else begin
			ack_q <= 1'b0;
			case (state_q)
				M_SEED0: begin
					p_q     <= seed;
					i_q     <= IW'(1);
					state_q <= M_SMUL;
				end
				M_SMUL: begin
					prod_q  <= rrs_pkg::MT_INIT_MUL * (p_q ^ (p_q >> 30));
					state_q <= M_SADD;
				end
				M_SADD: begin
					p_q <= seed_next;
					if (i_q == LAST_I) begin
						idx_q   <= N_I;
						state_q <= M_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= M_SMUL;
					end
				end
				M_IDLE: begin
					if (reseed) begin
						state_q <= M_SEED0;
					end else if (draw_req) begin
						if (idx_q >= N_I) begin
							i_q     <= '0;
							state_q <= M_TA;
						end else begin
							state_q <= M_DRD;
						end
					end
				end
				M_TA: state_q <= M_TB;
				M_TB: begin
					a_q     <= rdata;
					state_q <= M_TC;
				end
				M_TC: begin
					b_q     <= rdata;
					state_q <= M_TW;
				end
				M_TW: begin
					if (i_q == LAST_I) begin
						idx_q   <= '0;
						state_q <= M_DRD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= M_TA;
					end
				end
				M_DRD: state_q <= M_DTMP;
				M_DTMP: begin
					key_q   <= t3;
					ack_q   <= 1'b1;
					idx_q   <= idx_q + 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.busy = (state_q != M_IDLE);
		rsp.ack  = ack_q;
		rsp.key  = key_q;
	end
endmodule
`default_nettype wire

### design/rrs_back.sv
// Execution side: ring appends, shuffle build by insertion sort, row readout.
`default_nettype none
module rrs_back #(
	parameter int MAX_ENTRIES   = rrs_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_ROW_WORDS = rrs_pkg::MAX_ROW_WORDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rrs_pkg::cmd_t                 cmd,
	input  wire logic                          cmd_valid,
	output logic                               cmd_pop,
	output logic                               draw_req,
	input  wire rrs_pkg::mt_rsp_t              mt_rsp,
	input  wire logic [rrs_pkg::CAP_W-1:0]     capacity,
	input  wire logic [rrs_pkg::ROWW_W-1:0]    row_words,
	input  wire logic [rrs_pkg::BATCH_W-1:0]   batch_rows,
	output logic                               idle,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [rrs_pkg::TDATA_W-1:0]        m_tdata,
	output logic                               m_tlast,
	output logic [rrs_pkg::TUSER_W-1:0]        m_tuser
);
	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int WW  = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
	localparam int RWW = $clog2(MAX_ROW_WORDS + 1);
	localparam int SD  = MAX_ENTRIES * MAX_ROW_WORDS;
	localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
	localparam int BW  = rrs_pkg::BATCH_W;
	localparam logic [SAW-1:0] MRW_S = SAW'(MAX_ROW_WORDS);

	typedef enum logic [3:0] {
		B_IDLE, B_DRAW, B_WAIT, B_CMP, B_TEST, B_PLACE,
		B_ORD, B_SLOT, B_WRD, B_WOUT, B_EMPTY
	} back_state_t;

	back_state_t         state_q;
	logic [AW-1:0]       write_slot_q;
	logic [WW-1:0]       wir_q;
	logic [CW-1:0]       held_q;
	logic [CW-1:0]       order_len_q;
	logic [CW-1:0]       rp_q;
	logic                order_valid_q;
	logic [BW-1:0]       rib_q;
	logic [AW-1:0]       i_q;
	logic [CW-1:0]       n_q;
	logic [AW-1:0]       j_q;
	logic [31:0]         k_q;
	logic [AW-1:0]       slot_q;
	logic [WW-1:0]       w_q;
	logic                epoch_end_q;
	logic                batch_end_q;
	logic                out_valid_q;
	logic [rrs_pkg::DATA_W-1:0] out_data_q;
	logic                out_last_q;
	logic                out_batch_q;
	logic                out_epoch_q;
	logic                out_status_q;
	logic [rrs_pkg::STORED_W-1:0] out_stored_q;

	logic [31:0]         cap32;
	logic [CW-1:0]       cap_eff;
	logic [31:0]         rw32;
	logic [RWW-1:0]      rw_eff;
	logic [BW-1:0]       br_eff;
	logic [AW-1:0]       app_slot;
	logic [CW-1:0]       held_clamp;
	logic                row_done;
	logic                out_free;
	logic                word_last;
	logic                epoch_end;
	logic                batch_end;
	logic [31:0]         held32;

	logic                st_we;
	logic [SAW-1:0]      st_waddr;
	logic [SAW-1:0]      st_raddr;
	logic [rrs_pkg::DATA_W-1:0] st_rdata;
	logic                ok_we;
	logic [AW-1:0]       ok_waddr;
	logic [AW-1:0]       ok_raddr;
	logic [31:0]         key_wdata;
	logic [31:0]         key_rdata;
	logic [AW-1:0]       ord_wdata;
	logic [AW-1:0]       ord_rdata;

	always_comb begin
		cap32 = 32'(capacity);
		if (capacity == '0) begin
			cap32 = 32'd1;
		end else if (cap32 > 32'(MAX_ENTRIES)) begin
			cap32 = 32'(MAX_ENTRIES);
		end
		cap_eff = cap32[CW-1:0];
		rw32 = 32'(row_words);
		if (row_words == '0) begin
			rw32 = 32'd1;
		end else if (rw32 > 32'(MAX_ROW_WORDS)) begin
			rw32 = 32'(MAX_ROW_WORDS);
		end
		rw_eff = rw32[RWW-1:0];
		br_eff = (batch_rows == '0) ? BW'(1) : batch_rows;
	end

	assign app_slot   = (CW'(write_slot_q) < cap_eff) ? write_slot_q : '0;
	assign held_clamp = (held_q > cap_eff) ? cap_eff : held_q;
	assign row_done   = (RWW'(wir_q) + RWW'(1)) >= rw_eff;
	assign out_free   = !out_valid_q || m_tready;
	assign word_last  = (RWW'(w_q) + RWW'(1)) == rw_eff;
	assign epoch_end  = ({1'b0, rp_q} + (CW+1)'(1)) >= {1'b0, order_len_q};
	assign batch_end  = epoch_end || (({1'b0, rib_q} + (BW+1)'(1)) >= {1'b0, br_eff});
	assign held32     = 32'(held_q);

	assign cmd_pop  = (state_q == B_IDLE) && cmd_valid && !mt_rsp.busy;
	assign draw_req = (state_q == B_DRAW);
	assign idle     = (state_q == B_IDLE);

	// row store
	assign st_we    = cmd_pop && (cmd.kind == rrs_pkg::CMD_APPEND);
	assign st_waddr = SAW'(app_slot) * MRW_S + SAW'(wir_q);
	assign st_raddr = SAW'(slot_q) * MRW_S + SAW'(w_q);

	rrs_ram #(.W(rrs_pkg::DATA_W), .D(SD)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(cmd.word),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	// sort keys and order list share addressing
	always_comb begin
		ok_we     = 1'b0;
		ok_waddr  = j_q;
		key_wdata = key_rdata;
		ord_wdata = ord_rdata;
		ok_raddr  = rp_q[AW-1:0];
		case (state_q)
			B_CMP:  ok_raddr = j_q - 1'b1;
			B_TEST: ok_we = (k_q > key_rdata);
			B_PLACE: begin
				ok_we     = 1'b1;
				key_wdata = k_q;
				ord_wdata = i_q;
			end
			default: ;
		endcase
	end

	rrs_ram #(.W(32), .D(MAX_ENTRIES)) u_keys (
		.clk(clk), .we(ok_we), .waddr(ok_waddr), .wdata(key_wdata),
		.raddr(ok_raddr), .rdata(key_rdata)
	);

	rrs_ram #(.W(AW), .D(MAX_ENTRIES)) u_order (
		.clk(clk), .we(ok_we), .waddr(ok_waddr), .wdata(ord_wdata),
		.raddr(ok_raddr), .rdata(ord_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			write_slot_q  <= '0;
			wir_q         <= '0;
			held_q        <= '0;
			order_len_q   <= '0;
			rp_q          <= '0;
			order_valid_q <= 1'b0;
			rib_q         <= '0;
			i_q           <= '0;
			n_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			slot_q        <= '0;
			w_q           <= '0;
			epoch_end_q   <= 1'b0;
			batch_end_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
			out_last_q    <= 1'b0;
			out_batch_q   <= 1'b0;
			out_epoch_q   <= 1'b0;
			out_status_q  <= 1'b0;
			out_stored_q  <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (cmd_pop) begin
						if (cmd.kind == rrs_pkg::CMD_APPEND) begin
							if (row_done) begin
								wir_q        <= '0;
								write_slot_q <= ((CW'(app_slot) + CW'(1)) >= cap_eff) ? '0
								                : app_slot + 1'b1;
								held_q       <= (held_clamp < cap_eff) ? held_clamp + 1'b1
								                : held_clamp;
							end else begin
								wir_q        <= wir_q + 1'b1;
								write_slot_q <= app_slot;
								held_q       <= held_clamp;
							end
						end else if (order_valid_q) begin
							state_q <= B_ORD;
						end else if (held_q == '0) begin
							state_q <= B_EMPTY;
						end else begin
							i_q     <= '0;
							n_q     <= held_q;
							state_q <= B_DRAW;
						end
					end
				end
				B_DRAW: state_q <= B_WAIT;
				B_WAIT: begin
					if (mt_rsp.ack) begin
						k_q     <= mt_rsp.key;
						j_q     <= i_q;
						state_q <= B_CMP;
					end
				end
				B_CMP: state_q <= (j_q == '0) ? B_PLACE : B_TEST;
				B_TEST: begin
					// larger key moves the earlier entry up one place
					if (k_q > key_rdata) begin
						j_q     <= j_q - 1'b1;
						state_q <= B_CMP;
					end else begin
						state_q <= B_PLACE;
					end
				end
				B_PLACE: begin
					if ((CW'(i_q) + CW'(1)) == n_q) begin
						order_len_q   <= n_q;
						rp_q          <= '0;
						rib_q         <= '0;
						order_valid_q <= 1'b1;
						state_q       <= B_ORD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= B_DRAW;
					end
				end
				B_ORD: state_q <= B_SLOT;
				B_SLOT: begin
					slot_q      <= ord_rdata;
					w_q         <= '0;
					epoch_end_q <= epoch_end;
					batch_end_q <= batch_end;
					if (epoch_end) begin
						order_valid_q <= 1'b0;
						rp_q          <= '0;
						rib_q         <= '0;
					end else begin
						rp_q  <= rp_q + 1'b1;
						rib_q <= batch_end ? '0 : rib_q + 1'b1;
					end
					state_q <= B_WRD;
				end
				B_WRD: state_q <= B_WOUT;
				B_WOUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= st_rdata;
						out_last_q   <= word_last;
						out_batch_q  <= word_last && batch_end_q;
						out_epoch_q  <= word_last && epoch_end_q;
						out_status_q <= 1'b0;
						out_stored_q <= held32[rrs_pkg::STORED_W-1:0];
						if (word_last) begin
							state_q <= B_IDLE;
						end else begin
							w_q     <= w_q + 1'b1;
							state_q <= B_WRD;
						end
					end
				end
				B_EMPTY: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= '0;
						out_last_q   <= 1'b1;
						out_batch_q  <= 1'b0;
						out_epoch_q  <= 1'b0;
						out_status_q <= 1'b1;
						out_stored_q <= '0;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(rrs_pkg::TDATA_W - rrs_pkg::DATA_W - rrs_pkg::STORED_W)'(0),
	                   out_stored_q, out_data_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_status_q, out_epoch_q, out_batch_q};
endmodule
`default_nettype wire

### design/replay_ring_with_shuffled_readout.sv
// Replay ring with shuffled readout: an append is taken from the queue head while the
// key generator is not busy; a pulled row fetches its slot from the order list, then
// gives its words one by one (store RAM read, then output register), holding while the
// output stalls, and no command is taken before its last word. The first pull of an
// epoch builds the order: per row one key draw (with a twist of all 624 state entries
// when used up) and an insertion sort, O(rows^2) shifts in the worst case. After reset
// (arst_n low, asynchronous) or a seed write, the key generator reseeds; no command runs.
`default_nettype none
module replay_ring_with_shuffled_readout #(
	parameter int MAX_ENTRIES   = rrs_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_ROW_WORDS = rrs_pkg::MAX_ROW_WORDS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [rrs_pkg::DATA_W-1:0]      s_tdata,  // word
	input  wire logic                            s_tuser,  // mode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [rrs_pkg::TDATA_W-1:0]          m_tdata,  // data_word, stored_rows
	output logic                                 m_tlast,
	output logic [rrs_pkg::TUSER_W-1:0]          m_tuser,  // batch_last, epoch_last, status
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rrs_pkg::SEED_W-1:0]      cfg_data
);
	logic [rrs_pkg::CAP_W-1:0]   capacity_q;
	logic [rrs_pkg::ROWW_W-1:0]  row_words_q;
	logic [rrs_pkg::BATCH_W-1:0] batch_rows_q;
	logic [rrs_pkg::SEED_W-1:0]  seed_q;

	rrs_pkg::cmd_t    cmd;
	logic             cmd_valid;
	logic             cmd_pop;
	logic             draw_req;
	rrs_pkg::mt_rsp_t mt_rsp;
	logic             back_idle;
	logic             cfg_wr;
	logic             reseed;

	assign cfg_ready = back_idle && !cmd_valid && !mt_rsp.busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign reseed    = cfg_wr && (cfg_index == rrs_pkg::REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= rrs_pkg::CAP_RST;
			row_words_q  <= rrs_pkg::ROWW_RST;
			batch_rows_q <= rrs_pkg::BATCH_RST;
			seed_q       <= rrs_pkg::SEED_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				rrs_pkg::REG_CAPACITY:  capacity_q   <= cfg_data[rrs_pkg::CAP_W-1:0];
				rrs_pkg::REG_ROW_WORDS: row_words_q  <= cfg_data[rrs_pkg::ROWW_W-1:0];
				rrs_pkg::REG_BATCH:     batch_rows_q <= cfg_data[rrs_pkg::BATCH_W-1:0];
				rrs_pkg::REG_SEED:      seed_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	rrs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
	);

	rrs_mt u_mt (
		.clk(clk), .arst_n(arst_n), .seed(seed_q), .reseed(reseed),
		.draw_req(draw_req), .rsp(mt_rsp)
	);

	rrs_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_ROW_WORDS(MAX_ROW_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.draw_req(draw_req), .mt_rsp(mt_rsp),
		.capacity(capacity_q), .row_words(row_words_q), .batch_rows(batch_rows_q),
		.idle(back_idle),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);
endmodule
`default_nettype wire

### design/rrs_checker.sv
// Port-level checks for the replay ring, bound to the top level.
`default_nettype none
module rrs_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [rrs_pkg::TDATA_W-1:0]   m_tdata,
	input wire logic                          m_tlast,
	input wire logic [rrs_pkg::TUSER_W-1:0]   m_tuser
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast && (m_tdata == '0) && !m_tuser[0] && !m_tuser[1])
		else $error("empty-store word malformed");

	a_epoch_ends_batch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
		else $error("epoch end without batch end");

	a_batch_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("batch end off a row end");
endmodule

bind replay_ring_with_shuffled_readout rrs_checker u_rrs_checker (.*);
`default_nettype wire
